[hw/rtl/frl_pkg.sv]
package frl_pkg;

  // Default frame length limit
  localparam int unsigned MaxSamplesDef = 4096;

  // Fixed field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned LevelW   = 24;
  localparam int unsigned OutCntW  = 13;
  localparam int unsigned FracW    = 8;

  // Square of a 16-bit magnitude (at most 2^30)
  localparam int unsigned ProdW    = 31;

  // Root of the scaled mean square: mean <= 2^30, scaled by 2^16, root <= 2^23
  localparam int unsigned RootW    = LevelW;
  localparam int unsigned QuoW     = 2 * RootW;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } state_e;

  // Accumulator controls from the sequencer
  typedef struct packed {
    logic take;   // register the square of the sample
    logic add;    // fold the square into the frame sum
    logic clear;  // start a new frame
  } acc_ctrl_t;

endpackage

[hw/rtl/frame_rms_level_meter.sv]
// Each sample is accepted in ST_IDLE and accumulated in ST_ACC; in_stall_o is high in ST_ACC.
// A frame-closing sample then goes through ST_LOAD, the divide steps (ST_DIV), the root
// steps (ST_SQRT) and ST_FIN: one restoring divide step and one root step per cycle, all on
// one shared compare-subtract unit.
// A result waits in the output register; samples of the next frame are taken meanwhile.
// Reset (rst_ni low, asynchronous) clears the frame sum, count, flag and output valid.
module frame_rms_level_meter #(
  parameter int unsigned MAX_SAMPLES = frl_pkg::MaxSamplesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [frl_pkg::SampleW-1:0] sample_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [frl_pkg::LevelW-1:0]         rms_level_o,
  output logic [frl_pkg::OutCntW-1:0]        sample_count_o,
  output logic                               overflow_o
);

  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW  = frl_pkg::ProdW + $clog2(MAX_SAMPLES);
  localparam int unsigned DvdW  = SumW + 2 * frl_pkg::FracW;
  localparam int unsigned StepW = $clog2(DvdW + 1);
  localparam int unsigned RootW = frl_pkg::RootW;
  localparam int unsigned QuoW  = frl_pkg::QuoW;
  localparam int unsigned AluW  = (CntW + 1 > RootW + 3) ? CntW + 1 : RootW + 3;

  frl_pkg::state_e    state_q, state_d;
  frl_pkg::acc_ctrl_t acc_ctrl;

  logic [SumW-1:0]  sum;
  logic [CntW-1:0]  count;
  logic             ovf;

  logic             last_q;
  logic [StepW-1:0] step_q;
  logic [DvdW-1:0]  dvd_q;
  logic [CntW-1:0]  dcnt_q;
  logic             fovf_q;
  logic [CntW-1:0]  rem_q;
  logic [QuoW-1:0]  quo_q;
  logic [RootW:0]   srem_q;
  logic [RootW-1:0] root_q;

  logic             out_valid_q;
  logic [frl_pkg::LevelW-1:0]  rms_q;
  logic [frl_pkg::OutCntW-1:0] ocnt_q;
  logic             oovf_q;

  logic [AluW-1:0]  alu_a, alu_b, alu_diff;
  logic             alu_ge;
  logic [CntW:0]    div_t;
  logic [RootW+2:0] sq_t;
  logic [RootW+1:0] sq_trial;
  logic [CntW+frl_pkg::OutCntW-1:0] cnt_ext;
  logic             in_take, out_take, out_free, last_step;

  assign in_take  = in_valid_i && (state_q == frl_pkg::ST_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  frl_accum #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .sample_i(sample_i),
    .sum_o   (sum),
    .count_o (count),
    .ovf_o   (ovf)
  );

  // Operands of the shared unit: divide step or root step
  assign div_t    = {rem_q, dvd_q[DvdW-1]};
  assign sq_t     = {srem_q, quo_q[QuoW-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};

  always_comb begin
    if (state_q == frl_pkg::ST_DIV) begin
      alu_a = AluW'(div_t);
      alu_b = AluW'(dcnt_q);
    end else begin
      alu_a = AluW'(sq_t);
      alu_b = AluW'(sq_trial);
    end
  end

  frl_cmpsub #(
    .W(AluW)
  ) u_cmpsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ge_o  (alu_ge),
    .diff_o(alu_diff)
  );

  // Sequencer: next state and accumulator controls
  always_comb begin
    state_d   = state_q;
    acc_ctrl  = '0;
    last_step = 1'b0;
    case (state_q)
      frl_pkg::ST_IDLE: begin
        acc_ctrl.take = in_take;
        if (in_take) begin
          state_d = frl_pkg::ST_ACC;
        end
      end
      frl_pkg::ST_ACC: begin
        acc_ctrl.add = 1'b1;
        state_d = last_q ? frl_pkg::ST_LOAD : frl_pkg::ST_IDLE;
      end
      frl_pkg::ST_LOAD: begin
        acc_ctrl.clear = 1'b1;
        state_d = frl_pkg::ST_DIV;
      end
      frl_pkg::ST_DIV: begin
        last_step = (step_q == StepW'(DvdW - 1));
        if (last_step) begin
          state_d = frl_pkg::ST_SQRT;
        end
      end
      frl_pkg::ST_SQRT: begin
        last_step = (step_q == StepW'(RootW - 1));
        if (last_step) begin
          state_d = frl_pkg::ST_FIN;
        end
      end
      frl_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = frl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = frl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divide and root datapath
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      last_q <= last_i;
    end
    case (state_q)
      frl_pkg::ST_LOAD: begin
        dvd_q  <= {sum, {(2 * frl_pkg::FracW){1'b0}}};
        dcnt_q <= count;
        fovf_q <= ovf;
        rem_q  <= '0;
        step_q <= '0;
      end
      frl_pkg::ST_DIV: begin
        dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
        quo_q <= {quo_q[QuoW-2:0], alu_ge};
        rem_q <= alu_ge ? alu_diff[CntW-1:0] : div_t[CntW-1:0];
        if (last_step) begin
          step_q <= '0;
          srem_q <= '0;
          root_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      frl_pkg::ST_SQRT: begin
        quo_q  <= {quo_q[QuoW-3:0], 2'b00};
        srem_q <= alu_ge ? alu_diff[RootW:0] : sq_t[RootW:0];
        root_q <= {root_q[RootW-2:0], alu_ge};
        step_q <= step_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  assign cnt_ext = {{frl_pkg::OutCntW{1'b0}}, dcnt_q};

  always_ff @(posedge clk_i) begin
    if (state_q == frl_pkg::ST_FIN && out_free) begin
      rms_q  <= root_q;
      ocnt_q <= cnt_ext[frl_pkg::OutCntW-1:0];
      oovf_q <= fovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == frl_pkg::ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o     = (state_q != frl_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign rms_level_o    = rms_q;
  assign sample_count_o = ocnt_q;
  assign overflow_o     = oovf_q;

endmodule

[hw/rtl/frl_cmpsub.sv]
// Shared compare-and-subtract unit, used by every divide and root step
module frl_cmpsub #(
  parameter int unsigned W = 27
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge_o,
  output logic [W-1:0] diff_o
);

  logic borrow;

  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = ~borrow;

endmodule

[hw/rtl/frl_accum.sv]
// Square of each sample and the running frame sum, count and drop flag
module frl_accum #(
  parameter int unsigned MAX_SAMPLES = frl_pkg::MaxSamplesDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW = frl_pkg::ProdW + $clog2(MAX_SAMPLES)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  frl_pkg::acc_ctrl_t              ctrl_i,
  input  logic signed [frl_pkg::SampleW-1:0] sample_i,
  output logic [SumW-1:0]                 sum_o,
  output logic [CntW-1:0]                 count_o,
  output logic                            ovf_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  logic [frl_pkg::SampleW-1:0] mag;
  logic [2*frl_pkg::SampleW-1:0] sq;
  logic [frl_pkg::ProdW-1:0] prod_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;

  // Magnitude; the most negative sample maps to 0x8000 as wanted
  assign mag = sample_i[frl_pkg::SampleW-1] ? (~sample_i + 1'b1) : sample_i;
  assign sq  = mag * mag;

  // Square register, loaded on an accepted item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      prod_q <= sq[frl_pkg::ProdW-1:0];
    end
  end

  // Sum/count update; samples past the limit are dropped and flagged
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.add) begin
      if (cnt_q < MaxCnt) begin
        sum_d = sum_q + SumW'(prod_q);
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = cnt_q;
  assign ovf_o   = ovf_q;

endmodule

[hw/rtl/frl_checker.sv]
// Port-level checks for the level meter
module frl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic signed [frl_pkg::SampleW-1:0] sample_i,
  input logic                               last_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [frl_pkg::LevelW-1:0]         rms_level_o,
  input logic [frl_pkg::OutCntW-1:0]        sample_count_o,
  input logic                               overflow_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rms_level_o)
      && $stable(sample_count_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // A stalled input item holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i) && $stable(last_i))
    else $error("stalled input item changed");

  // Each accepted item is busy for at least its accumulate cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken without accumulate cycle");

  // A new result only appears at the end of a busy frame computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised outside frame finish");

  // The level never exceeds full scale (32768.0)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rms_level_o <= 24'd8388608)
    else $error("level above full scale");

endmodule

bind frame_rms_level_meter frl_checker u_frl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .sample_i      (sample_i),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .rms_level_o   (rms_level_o),
  .sample_count_o(sample_count_o),
  .overflow_o    (overflow_o)
);

[verif/tb_frame_rms_level_meter.sv]
`timescale 1ns / 100ps

module tb_frame_rms_level_meter;

  localparam int unsigned MaxSamples  = frl_pkg::MaxSamplesDef;
  localparam int unsigned RandItems   = 1300;
  localparam int unsigned TailItems   = 130;
  localparam int unsigned DirRows     = 21;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 120;

  // One frame result as the block reports it
  typedef struct packed {
    logic [frl_pkg::LevelW-1:0]  level;
    logic [frl_pkg::OutCntW-1:0] count;
    logic                        ovf;
  } rms_t;

  // Directed row: sample, last flag, and a hand-typed result where obvious
  typedef struct packed {
    logic signed [frl_pkg::SampleW-1:0] smp;
    logic                               lst;
    logic                               typed;
    rms_t                               res;
  } row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic signed [frl_pkg::SampleW-1:0] sample_i;
  logic                               last_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [frl_pkg::LevelW-1:0]         rms_level_o;
  logic [frl_pkg::OutCntW-1:0]        sample_count_o;
  logic                               overflow_o;

  // Frame levels still owed by the block, oldest first
  rms_t expected_levels[$];

  // Running frame state of the predictor
  logic [63:0] sq_sum   = '0;
  logic [63:0] n_taken  = '0;
  logic        dropped  = 1'b0;

  int unsigned errors      = 0;
  int unsigned frames_seen = 0;
  int unsigned ovf_seen    = 0;
  int unsigned items_sent  = 0;
  bit          calm           = 1'b0;
  bit          long_hold_done = 1'b0;

  row_t dir_rows [DirRows];

  frame_rms_level_meter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rms_level_o    (rms_level_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Integer square root, floor, built one result bit at a time
  function automatic logic [frl_pkg::LevelW-1:0] floor_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = frl_pkg::LevelW; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r[frl_pkg::LevelW-1:0];
  endfunction

  // Fold one sample into the frame; a last sample closes the frame
  function automatic void fold_sample(input logic signed [frl_pkg::SampleW-1:0] s,
                                      input logic l,
                                      output bit closes, output rms_t res);
    int          sv;
    logic [63:0] mag;
    closes = 1'b0;
    res    = '0;
    sv     = s;
    if (n_taken < MaxSamples) begin
      mag     = (sv < 0) ? 64'(-sv) : 64'(sv);
      sq_sum  = sq_sum + mag * mag;
      n_taken = n_taken + 1;
    end else begin
      dropped = 1'b1;
    end
    if (l) begin
      closes    = 1'b1;
      res.level = (n_taken != 0) ? floor_root((sq_sum << 16) / n_taken) : '0;
      res.count = n_taken[frl_pkg::OutCntW-1:0];
      res.ovf   = dropped;
      sq_sum    = '0;
      n_taken   = '0;
      dropped   = 1'b0;
    end
  endfunction

  // Sample values weighted toward the extremes and small magnitudes
  function automatic logic signed [frl_pkg::SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3, 4: v = int'($urandom_range(0, 511)) - 256;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return frl_pkg::SampleW'(v);
  endfunction

  // Mostly short frames, now and then a longer one
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      6, 7: return $urandom_range(9, 40);
      8: return $urandom_range(41, 200);
      9: return $urandom_range(1, 3);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Offer one item; on acceptance, update the predictor
  task automatic send_sample(input logic signed [frl_pkg::SampleW-1:0] s, input logic l,
                             input bit idle_ok, input bit typed, input rms_t typed_res);
    bit   closes;
    rms_t res;
    if (idle_ok && !calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_sample(s, l, closes, res);
    if (closes) expected_levels.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned len, input bit idle_ok);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(pick_sample(), (i == len - 1), idle_ok, 1'b0, '0);
    end
  endtask

  // Stimulus
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    last_i     = 1'b0;

    dir_rows = '{
      // single-sample frames: zero, both full-scale ends, unit steps
      '{16'sd0,      1'b1, 1'b1, '{24'd0,       13'd1, 1'b0}},
      '{16'sh8000,   1'b1, 1'b1, '{24'd8388608, 13'd1, 1'b0}},
      '{16'sd32767,  1'b1, 1'b1, '{24'd8388352, 13'd1, 1'b0}},
      '{-16'sd1,     1'b1, 1'b1, '{24'd256,     13'd1, 1'b0}},
      '{16'sd1,      1'b1, 1'b1, '{24'd256,     13'd1, 1'b0}},
      // mixed ends in one frame, then a small mixed-sign frame
      '{16'sh8000,   1'b0, 1'b0, '0},
      '{16'sd32767,  1'b1, 1'b0, '0},
      '{16'sd100,    1'b0, 1'b0, '0},
      '{-16'sd200,   1'b0, 1'b0, '0},
      '{16'sd300,    1'b1, 1'b0, '0},
      // full-scale negative frame: mean square is exactly 2^30
      '{16'sh8000,   1'b0, 1'b0, '0},
      '{16'sh8000,   1'b0, 1'b0, '0},
      '{16'sh8000,   1'b0, 1'b0, '0},
      '{16'sh8000,   1'b1, 1'b1, '{24'd8388608, 13'd4, 1'b0}},
      // alternating bit patterns
      '{16'sh5555,   1'b0, 1'b0, '0},
      '{16'shAAAA,   1'b1, 1'b0, '0},
      // truncated result with a zero in the frame, then an exact one
      '{16'sd3,      1'b0, 1'b0, '0},
      '{16'sd4,      1'b0, 1'b0, '0},
      '{16'sd0,      1'b1, 1'b0, '0},
      '{16'sd7,      1'b0, 1'b0, '0},
      '{16'sd7,      1'b1, 1'b0, '0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < DirRows; i++) begin
      send_sample(dir_rows[i].smp, dir_rows[i].lst, 1'b1, dir_rows[i].typed, dir_rows[i].res);
    end

    // random frames, idling switched per frame
    while (items_sent < DirRows + RandItems) begin
      send_frame(pick_length(), ($urandom_range(0, 3) != 0));
    end

    // closing stretch with no idling on either side
    calm = 1'b1;
    begin
      int unsigned tail_end;
      tail_end = items_sent + TailItems;
      while (items_sent < tail_end) send_frame(pick_length(), 1'b0);
    end
    in_valid_i <= 1'b0;

    wait (expected_levels.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d samples; checked %0d frame levels, %0d with dropped samples.",
             items_sent, frames_seen, ovf_seen);
    $display("Covered full-scale and zero frames, long output hold and input back-pressure.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output stall: random bursts, plus one long hold to back the block up
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && frames_seen >= 30) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i    <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expected level
  always @(posedge clk_i) begin
    rms_t want;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result: rms_level %0d sample_count %0d overflow %0d",
               rms_level_o, sample_count_o, overflow_o);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (rms_level_o !== want.level) begin
          $error("rms_level: expected %0d, got %0d", want.level, rms_level_o);
          errors++;
        end
        if (sample_count_o !== want.count) begin
          $error("sample_count: expected %0d, got %0d", want.count, sample_count_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0d, got %0d", want.ovf, overflow_o);
          errors++;
        end
        frames_seen++;
        if (want.ovf) ovf_seen++;
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("Timeout with %0d frame levels outstanding.", expected_levels.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/frl_pkg.sv
hw/rtl/frl_cmpsub.sv
hw/rtl/frl_accum.sv
hw/rtl/frame_rms_level_meter.sv
hw/rtl/frl_checker.sv
verif/tb_frame_rms_level_meter.sv
